/* sv/rse_pkg.sv */
// Package for the execute unit: opcodes, status codes, preset tables and the result struct.
`default_nettype none

package rse_pkg;

   localparam int DEF_MEM_ADDR_BITS = 20;

   localparam logic [31:0] PC_RESET  = 32'h0000_1000;
   localparam logic [31:0] SP_RESET  = 32'h0000_8000;
   localparam logic [31:0] HALT_WORD = 32'hffff_ffff;
   localparam logic [31:0] JUMP_MASK = 32'hf000_0000;

   // status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_HALT = 2'd1;
   localparam logic [1:0] STAT_BAD  = 2'd2;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_SLTI    = 6'h0a;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2b;

   // function codes under OP_SPECIAL
   localparam logic [5:0] FN_SLL = 6'h00;
   localparam logic [5:0] FN_SRL = 6'h02;
   localparam logic [5:0] FN_SRA = 6'h03;
   localparam logic [5:0] FN_JR  = 6'h08;
   localparam logic [5:0] FN_ADD = 6'h20;
   localparam logic [5:0] FN_SUB = 6'h22;
   localparam logic [5:0] FN_AND = 6'h24;
   localparam logic [5:0] FN_OR  = 6'h25;
   localparam logic [5:0] FN_NOR = 6'h27;
   localparam logic [5:0] FN_SLT = 6'h2a;

   localparam logic [4:0] LINK_REG = 5'd31;

   localparam logic [7:0] MEM_PRESET [64] = '{
      8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77,
      8'hde, 8'had, 8'hbe, 8'hef, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h68, 8'h65, 8'h6c, 8'h6c, 8'h6f, 8'h20, 8'h77, 8'h6f,
      8'h72, 8'h6c, 8'h64, 8'h21, 8'h21, 8'h00, 8'h00, 8'h00,
      8'h61, 8'h77, 8'h65, 8'h73, 8'h6f, 8'h6d, 8'h65, 8'h20,
      8'h63, 8'h6f, 8'h6d, 8'h70, 8'h75, 8'h74, 8'h65, 8'h72,
      8'h20, 8'h61, 8'h72, 8'h63, 8'h68, 8'h69, 8'h74, 8'h65,
      8'h63, 8'h74, 8'h75, 8'h72, 8'h65, 8'h21, 8'h00, 8'h00
   };

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] next_pc;
      logic        wr;
      logic [4:0]  widx;
      logic [31:0] wval;
      logic        mw;
      logic [31:0] mword;
      logic [31:0] eff_addr;
      logic        is_load;
   } exec_result_type;

   function automatic logic [7:0] preset_byte(input logic [5:0] idx);
      return MEM_PRESET[idx];
   endfunction

   function automatic logic [31:0] rf_preset(input logic [4:0] idx);
      logic [31:0] v;
      v = '0;
      case (idx)
         5'd16:   v = 32'h0000_0010;
         5'd17:   v = PC_RESET;
         5'd18:   v = 32'h0000_0020;
         5'd19:   v = 32'h0000_0003;
         5'd20:   v = 32'hbada_cafe;
         5'd21:   v = 32'hcdcd_cdcd;
         5'd22:   v = 32'hffff_ffff;
         5'd23:   v = 32'h0000_0007;
         5'd29:   v = SP_RESET;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* sv/risc_subset_execute_unit.sv */
// Top level of the execute unit: register file, byte memory banks, pipeline and handshakes.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_stall   req_instruction
//   rsp      out  rsp_valid / rsp_stall   status, next_pc, reg_*, mem_*
//
// A transaction enters execute on the edge that accepts it; that edge also issues its
// register read. A non-load retires as its result is registered, so one transaction per
// cycle is sustained while rsp_stall is low. Loads have a read and a data phase: the byte
// banks have a registered read port. After reset, a clearing pass over 2**(MEM_ADDR_BITS-2)
// rows writes the memory bank and register file presets; req_stall is high meanwhile. While
// rsp_stall is high the result holds and one more transaction can wait in execute.
`default_nettype none

module risc_subset_execute_unit
   import rse_pkg::*;
#(
   parameter int MEM_ADDR_BITS = DEF_MEM_ADDR_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instruction,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_reg_index,
   output logic [31:0]      rsp_reg_value,
   output logic             rsp_mem_written,
   output logic [19:0]      rsp_mem_address,
   output logic [31:0]      rsp_mem_word
);

   localparam int ROW_BITS = MEM_ADDR_BITS - 2;
   localparam int ROWS     = 1 << ROW_BITS;
   localparam logic [31:0] MEM_MASK = 32'((64'd1 << MEM_ADDR_BITS) - 64'd1);

   // clearing pass
   logic                init_ff, init_in;
   logic [ROW_BITS-1:0] init_cnt_ff, init_cnt_in;
   logic                init_rf_we;

   // execute stage
   logic            ex_valid_ff, ex_valid_in;
   logic [31:0]     ins_ff, ins_in;
   logic            ld_phase_ff, ld_phase_in;
   logic            fwd_a_hit_ff, fwd_a_hit_in;
   logic            fwd_b_hit_ff, fwd_b_hit_in;
   logic [31:0]     fwd_a_ff, fwd_a_in;
   logic [31:0]     fwd_b_ff, fwd_b_in;
   logic [31:0]     pc_ff, pc_in;
   logic [31:0]     op_a, op_b;
   exec_result_type ex;

   logic accept, out_free, ex_done;
   logic [31:0] load_word;
   logic [31:0] wr_value;

   // register file
   logic        rf_we;
   logic [4:0]  rf_waddr;
   logic [31:0] rf_wdata;
   logic [31:0] rf_a_rdata, rf_b_rdata;

   // byte banks
   logic                mem_rd_en, mem_we_ex;
   logic [1:0]          addr_lo;
   logic [ROW_BITS-1:0] base_row;
   logic                bank_we    [4];
   logic [ROW_BITS-1:0] bank_waddr [4];
   logic [7:0]          bank_wdata [4];
   logic [ROW_BITS-1:0] bank_raddr [4];
   logic [7:0]          bank_rdata [4];

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_next_pc_ff;
   logic        rsp_reg_written_ff;
   logic [4:0]  rsp_reg_index_ff;
   logic [31:0] rsp_reg_value_ff;
   logic        rsp_mem_written_ff;
   logic [19:0] rsp_mem_address_ff;
   logic [31:0] rsp_mem_word_ff;
   logic [31:0] masked_addr;

   rse_alu u_alu (
      .instruction (ins_ff),
      .op_a        (op_a),
      .op_b        (op_b),
      .pc          (pc_ff),
      .res         (ex)
   );

   assign op_a = fwd_a_hit_ff ? fwd_a_ff : rf_a_rdata;
   assign op_b = fwd_b_hit_ff ? fwd_b_ff : rf_b_rdata;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ex_done   = ex_valid_ff && out_free && (!ex.is_load || ld_phase_ff);
   assign req_stall = init_ff || (ex_valid_ff && !ex_done);
   assign accept    = req_valid && !req_stall;

   // clearing pass
   assign init_rf_we = init_ff && (init_cnt_ff[ROW_BITS-1:5] == '0);

   always_comb begin
      init_in     = init_ff;
      init_cnt_in = init_cnt_ff;
      if (init_ff) begin
         init_cnt_in = init_cnt_ff + 1'b1;
         if (&init_cnt_ff) begin
            init_in = 1'b0;
         end
      end
   end

   // load word assembly: byte j of the word sits in bank (addr + j) mod 4
   assign addr_lo  = ex.eff_addr[1:0];
   assign base_row = ex.eff_addr[MEM_ADDR_BITS-1:2];

   always_comb begin
      logic [1:0] bank;
      load_word = '0;
      for (int j = 0; j < 4; j++) begin
         bank = addr_lo + 2'(j);
         load_word[8*(3-j) +: 8] = bank_rdata[bank];
      end
   end

   assign wr_value = ex.is_load ? load_word : ex.wval;

   // register file write port: clearing pass or retiring transaction
   assign rf_we    = init_rf_we || (ex_done && ex.wr);
   assign rf_waddr = init_ff ? init_cnt_ff[4:0] : ex.widx;
   assign rf_wdata = init_ff ? rf_preset(init_cnt_ff[4:0]) : wr_value;

   rse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (accept),
      .rd_addr (req_instruction[25:21]),
      .rd_data (rf_a_rdata)
   );

   rse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (accept),
      .rd_addr (req_instruction[20:16]),
      .rd_data (rf_b_rdata)
   );

   // byte bank addressing
   assign mem_rd_en = ex_valid_ff && ex.is_load && !ld_phase_ff;
   assign mem_we_ex = ex_done && ex.mw;

   always_comb begin
      logic [ROW_BITS-1:0] row;
      logic [1:0]          j;
      logic [4:0]          shift;
      for (int k = 0; k < 4; k++) begin
         // bytes below the start address within a row wrap to the next row
         row   = base_row + {{(ROW_BITS-1){1'b0}}, (2'(k) < addr_lo)};
         j     = 2'(k) - addr_lo;
         shift = {2'd3 - j, 3'b000};
         bank_raddr[k] = row;
         if (init_ff) begin
            bank_we[k]    = 1'b1;
            bank_waddr[k] = init_cnt_ff;
            bank_wdata[k] = (init_cnt_ff[ROW_BITS-1:4] == '0) ?
                            preset_byte({init_cnt_ff[3:0], 2'(k)}) : 8'h00;
         end else begin
            bank_we[k]    = mem_we_ex;
            bank_waddr[k] = row;
            bank_wdata[k] = 8'(ex.mword >> shift);
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      rse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[g]),
         .wr_addr (bank_waddr[g]),
         .wr_data (bank_wdata[g]),
         .rd_en   (mem_rd_en),
         .rd_addr (bank_raddr[g]),
         .rd_data (bank_rdata[g])
      );
   end

   // execute stage control
   always_comb begin
      ex_valid_in  = ex_valid_ff;
      ins_in       = ins_ff;
      ld_phase_in  = ld_phase_ff;
      fwd_a_hit_in = fwd_a_hit_ff;
      fwd_b_hit_in = fwd_b_hit_ff;
      fwd_a_in     = fwd_a_ff;
      fwd_b_in     = fwd_b_ff;
      pc_in        = pc_ff;
      if (mem_rd_en) begin
         ld_phase_in = 1'b1;
      end
      if (ex_done) begin
         ex_valid_in  = 1'b0;
         ld_phase_in  = 1'b0;
         fwd_a_hit_in = 1'b0;
         fwd_b_hit_in = 1'b0;
         pc_in        = ex.next_pc;
      end
      if (accept) begin
         // the retiring write lands on the same edge as the new read, so bypass it
         ex_valid_in  = 1'b1;
         ins_in       = req_instruction;
         ld_phase_in  = 1'b0;
         fwd_a_hit_in = ex_done && ex.wr && (ex.widx == req_instruction[25:21]);
         fwd_b_hit_in = ex_done && ex.wr && (ex.widx == req_instruction[20:16]);
         fwd_a_in     = wr_value;
         fwd_b_in     = wr_value;
      end
   end

   // result register
   assign masked_addr  = ex.eff_addr & MEM_MASK;
   assign rsp_valid_in = ex_done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= 1'b1;
         init_cnt_ff  <= '0;
         ex_valid_ff  <= 1'b0;
         ld_phase_ff  <= 1'b0;
         fwd_a_hit_ff <= 1'b0;
         fwd_b_hit_ff <= 1'b0;
         pc_ff        <= PC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_ff      <= init_in;
         init_cnt_ff  <= init_cnt_in;
         ex_valid_ff  <= ex_valid_in;
         ld_phase_ff  <= ld_phase_in;
         fwd_a_hit_ff <= fwd_a_hit_in;
         fwd_b_hit_ff <= fwd_b_hit_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff   <= ins_in;
      fwd_a_ff <= fwd_a_in;
      fwd_b_ff <= fwd_b_in;
      if (ex_done) begin
         rsp_status_ff      <= ex.status;
         rsp_next_pc_ff     <= ex.next_pc;
         rsp_reg_written_ff <= ex.wr;
         rsp_reg_index_ff   <= ex.widx;
         rsp_reg_value_ff   <= ex.wr ? wr_value : 32'd0;
         rsp_mem_written_ff <= ex.mw;
         rsp_mem_address_ff <= ex.mw ? masked_addr[19:0] : 20'd0;
         rsp_mem_word_ff    <= ex.mword;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_reg_written = rsp_reg_written_ff;
   assign rsp_reg_index   = rsp_reg_index_ff;
   assign rsp_reg_value   = rsp_reg_value_ff;
   assign rsp_mem_written = rsp_mem_written_ff;
   assign rsp_mem_address = rsp_mem_address_ff;
   assign rsp_mem_word    = rsp_mem_word_ff;

   // a load read is always followed by its data phase in execute
   a_load_phase: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |=> (ex_valid_ff && ld_phase_ff))
      else $error("load lost its data phase");

   // bypass flags only live with a transaction in execute
   a_fwd_live: assert property (@(posedge clock) disable iff (reset)
      (fwd_a_hit_ff || fwd_b_hit_ff) |-> ex_valid_ff)
      else $error("stale bypass flag");

   // register zero is only written by the clearing pass
   a_no_r0: assert property (@(posedge clock) disable iff (reset)
      (rf_we && !init_ff) |-> (rf_waddr != 5'd0))
      else $error("write to register zero");

   // the clearing pass never restarts without reset
   a_init_once: assert property (@(posedge clock) disable iff (reset)
      !init_ff |=> !init_ff)
      else $error("clearing pass restarted");

   // a store never retires while a load read is outstanding
   a_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_we_ex))
      else $error("memory read and store in one cycle");

endmodule

`default_nettype wire

/* sv/rse_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/rse_alu.sv */
// Instruction decode and combinational execute datapath.
`default_nettype none

module rse_alu
   import rse_pkg::*;
(
   input  wire logic [31:0]     instruction,
   input  wire logic [31:0]     op_a,
   input  wire logic [31:0]     op_b,
   input  wire logic [31:0]     pc,
   output exec_result_type      res
);

   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [31:0] simm;
   logic [31:0] zimm;
   logic [31:0] pc4;
   logic [31:0] br_target;

   assign op        = instruction[31:26];
   assign rt        = instruction[20:16];
   assign rd        = instruction[15:11];
   assign sh        = instruction[10:6];
   assign fn        = instruction[5:0];
   assign simm      = {{16{instruction[15]}}, instruction[15:0]};
   assign zimm      = {16'h0000, instruction[15:0]};
   assign pc4       = pc + 32'd4;
   assign br_target = pc4 + {simm[29:0], 2'b00};

   always_comb begin
      res          = '0;
      res.status   = STAT_OK;
      res.next_pc  = pc4;
      res.eff_addr = op_a + simm;
      res.is_load  = 1'b0;
      if (instruction == HALT_WORD) begin
         res.status = STAT_HALT;
      end else if (op == OP_SPECIAL) begin
         res.wr   = 1'b1;
         res.widx = rd;
         unique case (fn)
            FN_ADD: res.wval = op_a + op_b;
            FN_SUB: res.wval = op_a - op_b;
            FN_AND: res.wval = op_a & op_b;
            FN_OR:  res.wval = op_a | op_b;
            FN_NOR: res.wval = ~(op_a | op_b);
            FN_SLL: res.wval = op_b << sh;
            FN_SRL: res.wval = op_b >> sh;
            FN_SRA: res.wval = 32'($signed(op_b) >>> sh);
            FN_SLT: res.wval = {31'd0, $signed(op_a) < $signed(op_b)};
            FN_JR: begin
               res.wr      = 1'b0;
               res.next_pc = op_a;
            end
            default: begin
               res.wr     = 1'b0;
               res.status = STAT_BAD;
            end
         endcase
      end else begin
         unique case (op) inside
            OP_ADDI: begin
               res.wr   = 1'b1;
               res.widx = rt;
               res.wval = op_a + simm;
            end
            OP_ANDI: begin
               res.wr   = 1'b1;
               res.widx = rt;
               res.wval = op_a & zimm;
            end
            OP_ORI: begin
               res.wr   = 1'b1;
               res.widx = rt;
               res.wval = op_a | zimm;
            end
            OP_SLTI: begin
               res.wr   = 1'b1;
               res.widx = rt;
               res.wval = {31'd0, $signed(op_a) < $signed(simm)};
            end
            OP_LW: begin
               // value comes from memory through the registered bank read, in the load's data phase
               res.wr      = 1'b1;
               res.widx    = rt;
               res.is_load = 1'b1;
            end
            OP_SW: begin
               res.mw    = 1'b1;
               res.mword = op_b;
            end
            OP_BEQ: begin
               if (op_a == op_b) begin
                  res.next_pc = br_target;
               end
            end
            OP_BNE: begin
               if (op_a != op_b) begin
                  res.next_pc = br_target;
               end
            end
            OP_J, OP_JAL: begin
               res.next_pc = (pc4 & JUMP_MASK) | {4'h0, instruction[25:0], 2'b00};
               if (op == OP_JAL) begin
                  res.wr   = 1'b1;
                  res.widx = LINK_REG;
                  res.wval = pc4;
               end
            end
            default: res.status = STAT_BAD;
         endcase
      end
      // register zero is hardwired
      if (res.wr && res.widx == 5'd0) begin
         res.wr = 1'b0;
      end
      if (!res.wr) begin
         res.widx = '0;
         res.wval = '0;
      end
   end

endmodule

`default_nettype wire
